### hw/rtl/signed_int_to_decimal_ascii_assert.svh
// assertion macros used by sida_back
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SIDA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sida assertion failed");

// next-cycle implication, checked out of reset
`define SIDA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sida assertion failed");

`endif

### hw/rtl/sida_pkg.sv
`timescale 1ns / 1ps

package sida_pkg;

    localparam int CHAR_W  = 6;
    localparam int DIGIT_W = 4;

    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [DIGIT_W-1:0] digit_t;

    localparam char_t ASCII_ZERO  = 6'd48;
    localparam char_t ASCII_MINUS = 6'd45;

endpackage

### hw/rtl/sida_if.sv
`timescale 1ns / 1ps

interface sida_value_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sida_char_if;
    import sida_pkg::*;

    logic  valid;
    logic  ready;
    char_t character;
    logic  last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

### hw/rtl/sida_front.sv
`timescale 1ns / 1ps

module sida_front #(
    parameter int VALUE_WIDTH = 32
) (
    sida_value_if.sink              num,
    output logic                    push_valid,
    input  logic                    push_ready,
    output logic [VALUE_WIDTH:0]    push_data
);
    import sida_pkg::*;

    logic [VALUE_WIDTH-1:0] val;
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;

    assign val = num.value;
    assign neg = val[VALUE_WIDTH-1];
    // most negative value negates to itself, which is the right unsigned magnitude
    assign mag = neg ? (~val + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : val;

    assign push_valid = num.valid;
    assign num.ready  = push_ready;
    assign push_data  = {neg, mag};

endmodule

### hw/rtl/sida_queue.sv
`timescale 1ns / 1ps

module sida_queue #(
    parameter int DATA_WIDTH = 33
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  logic [DATA_WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output logic [DATA_WIDTH-1:0] pop_data
);
    import sida_pkg::*;

    logic [DATA_WIDTH-1:0] mem [2];
    logic                  wr_ptr_reg;
    logic                  wr_ptr_next;
    logic                  rd_ptr_reg;
    logic                  rd_ptr_next;
    logic [1:0]            count_reg;
    logic [1:0]            count_next;
    logic                  push;
    logic                  pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem[rd_ptr_reg];

    assign push = push_valid && push_ready;
    assign pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/sida_back.sv
`timescale 1ns / 1ps

module sida_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  logic [VALUE_WIDTH:0]  pop_data,
    sida_char_if.source           text
);
    import sida_pkg::*;

    // enough decimal digits for 2^(VALUE_WIDTH-1)
    localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int CNT_W      = $clog2(VALUE_WIDTH);
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_FIND  = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_DIGIT = 3'd4;

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [VALUE_WIDTH-1:0] mag_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic [BCD_W-1:0]       bcd_reg;
    logic [BCD_W-1:0]       bcd_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       idx_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    char_t                  char_reg;
    char_t                  char_next;
    logic                   last_reg;
    logic                   last_next;

    digit_t                 digit_arr [NUM_DIGITS];
    logic [BCD_W-1:0]       bcd_adj;
    logic [IDX_W-1:0]       msd;
    digit_t                 cur_digit;
    logic                   slot_free;
    logic                   pop;

    // shift-and-add-3 correction, one per digit
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            digit_arr[i] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            bcd_adj[i*DIGIT_W +: DIGIT_W] = (digit_arr[i] >= 4'd5)
                ? (digit_arr[i] + 4'd3) : digit_arr[i];
        end
    end

    // position of the leading nonzero digit, zero if all digits are zero
    always_comb
    begin
        msd = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (digit_arr[i] != 4'd0)
            begin
                msd = IDX_W'(i);
            end
        end
    end

    assign cur_digit = digit_arr[idx_reg];
    assign slot_free = !out_valid_reg || text.ready;
    assign pop_ready = (state_reg == ST_IDLE);
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !text.ready;
        char_next      = char_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    neg_next   = pop_data[VALUE_WIDTH];
                    mag_next   = pop_data[VALUE_WIDTH-1:0];
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_WIDTH-1]};
                mag_next = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_FIND;
                end
            end
            ST_FIND:
            begin
                idx_next   = msd;
                state_next = neg_reg ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = ASCII_MINUS;
                    last_next      = 1'b0;
                    state_next     = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = ASCII_ZERO + {2'b00, cur_digit};
                    last_next      = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - {{(IDX_W-1){1'b0}}, 1'b1};
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
        idx_reg  <= idx_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign text.valid     = out_valid_reg;
    assign text.character = char_reg;
    assign text.last      = last_reg;

`include "signed_int_to_decimal_ascii_assert.svh"

    `SIDA_ASSERT_NOW(a_digit_is_decimal, (state_reg == ST_DIGIT), (cur_digit <= 4'd9))
    `SIDA_ASSERT_NOW(a_minus_not_last, (out_valid_reg && (char_reg == ASCII_MINUS)), (!last_reg))
    `SIDA_ASSERT_NEXT(a_last_ends_item, ((state_reg == ST_DIGIT) && slot_free && (idx_reg == '0)), (state_reg == ST_IDLE))
    `SIDA_ASSERT_NOW(a_conv_count_range, (state_reg == ST_CONV), (cnt_reg <= CNT_LAST))

endmodule

### hw/rtl/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps

// channel | role | payload
// num     | sink | value (VALUE_WIDTH bits, two's complement)
// text    | src  | character (6 bits ascii), last (1 bit)
//
// each item goes through the converter in order (load, one
// double-dabble step per magnitude bit, leading digit search), then
// its characters, up to 11 at 32 bits, go out one by one as text takes them
// a two-entry queue sits between the front and the converter
// rst_n clears control state only; results wait in an output register
module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    sida_value_if.sink  num,
    sida_char_if.source text
);
    import sida_pkg::*;

    logic                 push_valid;
    logic                 push_ready;
    logic [VALUE_WIDTH:0] push_data;
    logic                 pop_valid;
    logic                 pop_ready;
    logic [VALUE_WIDTH:0] pop_data;

    sida_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .num        (num),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    sida_queue #(
        .DATA_WIDTH (VALUE_WIDTH + 1)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    sida_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .text      (text)
    );

endmodule
